/* design/fco_pkg.sv */
// Shared types, constants and the quarter-wave sine table function for the fly camera.
`default_nettype none
package fco_pkg;

	localparam int SINE_TABLE_BITS_DEF = 10;

	localparam int MUL_A_W  = 17;
	localparam int MUL_B_W  = 22;
	localparam int PROD_W   = MUL_A_W + MUL_B_W;
	localparam int ACC_W    = 54;
	localparam int SINE_W   = 14;
	localparam int PHASE_W  = 24;

	localparam logic [PHASE_W-1:0] QUARTER_TURN = 24'h400000;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	localparam logic [1:0] OP_ROTATE = 2'd0;
	localparam logic [1:0] OP_KEY    = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;

	localparam logic [1:0] KEY_FORWARD = 2'd0;
	localparam logic [1:0] KEY_BACK    = 2'd1;
	localparam logic [1:0] KEY_LEFT    = 2'd2;
	localparam logic [1:0] KEY_RIGHT   = 2'd3;

	localparam logic [1:0] CFG_MOVE_SPEED  = 2'd0;
	localparam logic [1:0] CFG_YAW_SENS    = 2'd1;
	localparam logic [1:0] CFG_PITCH_SENS  = 2'd2;

	typedef struct packed {
		logic issue;
		logic clear;
		logic shift16;
	} mac_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_ROT  = 4'b0010,
		ST_TICK = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	// Q30 Taylor series of sin, rounded to Q12; entry i of a quarter wave
	function automatic logic [12:0] qsine(input int unsigned i, input int unsigned bits);
		longint unsigned x, x2, t3, t5, t7, t9, s;
		x  = (longint'(i) * HALF_PI_Q30) >> (bits - 2);
		x2 = (x * x) >> 30;
		t3 = ((x * x2) >> 30) / 6;
		t5 = ((t3 * x2) >> 30) / 20;
		t7 = ((t5 * x2) >> 30) / 42;
		t9 = ((t7 * x2) >> 30) / 72;
		s  = x - t3 + t5 - t7 + t9;
		return 13'((s + 64'd131072) >> 18);
	endfunction

endpackage
`default_nettype wire

/* design/fco_sine.sv */
// Quarter-wave sine lookup with registered output.
`default_nettype none
module fco_sine #(
	parameter int TABLE_BITS = fco_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic [fco_pkg::PHASE_W-1:0]         phase,
	output logic signed [fco_pkg::SINE_W-1:0]   sine
);
	import fco_pkg::*;

	localparam int QLEN = 1 << (TABLE_BITS - 2);

	logic [12:0] tbl [QLEN+1];
	logic [TABLE_BITS-1:0] idx;
	logic [TABLE_BITS-3:0] k;
	logic [TABLE_BITS-2:0] addr;
	logic signed [SINE_W-1:0] mag;

	for (genvar g = 0; g <= QLEN; g++) begin : g_tbl
		assign tbl[g] = qsine(g, TABLE_BITS);
	end

	assign idx = phase[PHASE_W-1 -: TABLE_BITS];
	assign k   = idx[TABLE_BITS-3:0];

	always_comb begin
		// mirror the index in the second and fourth quarter
		if (idx[TABLE_BITS-2]) begin
			addr = (TABLE_BITS-1)'(QLEN) - {1'b0, k};
		end else begin
			addr = {1'b0, k};
		end
		mag = signed'({1'b0, tbl[addr]});
	end

	always_ff @(posedge clk) begin
		sine <= idx[TABLE_BITS-1] ? -mag : mag;
	end

endmodule
`default_nettype wire

/* design/fco_mac.sv */
// Shared multiply-accumulate unit: registered product, then accumulate.
`default_nettype none
module fco_mac (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic signed [fco_pkg::MUL_A_W-1:0]   a,
	input  logic signed [fco_pkg::MUL_B_W-1:0]   b,
	input  fco_pkg::mac_ctl_t                    ctl,
	output logic signed [fco_pkg::ACC_W-1:0]     acc
);
	import fco_pkg::*;

	logic signed [PROD_W-1:0] prod_s1;
	mac_ctl_t ctl_s1;
	logic signed [ACC_W-1:0] addend, base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

	always_comb begin
		addend = ctl_s1.shift16 ? (ACC_W'(prod_s1) <<< 16) : ACC_W'(prod_s1);
		base   = ctl_s1.clear ? '0 : acc;
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.issue) begin
			acc <= base + addend;
		end
	end

endmodule
`default_nettype wire

/* design/fly_camera_orientation_and_motion.sv */
// Top level: fly camera state, sequencer and output register.
// Rotate and tick results are paced by the steps of the single shared two-stage
// multiply-accumulate unit and the registered sine lookup; key and unused ops
// go straight from accept to the done state.
// One item at a time: input ready only while the sequencer idles, a finished
// result waits in the output register while the next item is taken.
// Reset (arst_n low, asynchronous): control and camera registers to defaults, camera at (0,0,-5).
`default_nettype none
module fly_camera_orientation_and_motion #(
	parameter int SINE_TABLE_BITS = fco_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// delta_yaw[11:0], delta_pitch[23:12], key_code[25:24], pressed[26], elapsed[42:27]
	input  logic [47:0]  s_tdata,
	// op[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// pos_x, pos_y, pos_z (32 each), dir_x, dir_y, dir_z, right_x, right_z,
	// up_x, up_y, up_z (16 each)
	output logic [223:0] m_tdata
);
	import fco_pkg::*;

	state_t state_q;
	logic [4:0] step_q;
	logic [1:0] axis_q;

	logic [15:0] move_speed_q, yaw_sens_q, pitch_sens_q;
	logic [PHASE_W-1:0] yaw_q, pitch_q;
	logic signed [3:0] fwd_q, side_q;
	logic signed [31:0] pos_q [3];
	logic signed [15:0] dir_q [3];
	logic signed [15:0] right_x_q, right_z_q;
	logic signed [15:0] up_q [3];

	logic signed [11:0] dy_q, dp_q;
	logic [15:0] elapsed_q;
	logic signed [SINE_W-1:0] sy_q, cy_q, sp_q, cp_q;
	logic [31:0] base_q;
	logic signed [19:0] m_q;

	logic signed [MUL_A_W-1:0] mac_a;
	logic signed [MUL_B_W-1:0] mac_b;
	mac_ctl_t mac_ctl;
	logic signed [ACC_W-1:0] acc;
	logic [PHASE_W-1:0] sin_phase;
	logic signed [SINE_W-1:0] sine;

	logic signed [15:0] dir_sel, rv_sel;
	logic signed [ACC_W-1:0] t_round;
	logic signed [34:0] pos_sum;
	logic signed [31:0] pos_new;
	logic in_acc;

	function automatic logic signed [15:0] q12(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] r;
		r = v + ACC_W'(2048);
		return r[27:12];
	endfunction

	function automatic logic signed [3:0] step_count(input logic signed [3:0] c,
			input logic up);
		logic signed [4:0] s;
		s = 5'(c) + (up ? 5'sd1 : -5'sd1);
		if (s > 5'sd7) begin
			return 4'sd7;
		end else if (s < -5'sd8) begin
			return -4'sd8;
		end
		return s[3:0];
	endfunction

	fco_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.a      (mac_a),
		.b      (mac_b),
		.ctl    (mac_ctl),
		.acc    (acc)
	);

	fco_sine #(.TABLE_BITS(SINE_TABLE_BITS)) u_sine (
		.clk   (clk),
		.phase (sin_phase),
		.sine  (sine)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;

	always_comb begin
		unique case (axis_q)
			2'd0: begin
				dir_sel = dir_q[0];
				rv_sel  = right_x_q;
			end
			2'd1: begin
				dir_sel = dir_q[1];
				rv_sel  = '0;
			end
			default: begin
				dir_sel = dir_q[2];
				rv_sel  = right_z_q;
			end
		endcase
	end

	// operand selection for the shared unit
	always_comb begin
		mac_a     = '0;
		mac_b     = '0;
		mac_ctl   = '0;
		sin_phase = yaw_q;
		if (state_q == ST_ROT) begin
			unique case (step_q)
				5'd0: begin
					mac_a   = MUL_A_W'(yaw_sens_q);
					mac_b   = MUL_B_W'(dy_q);
					mac_ctl = '{issue: 1'b1, clear: 1'b1, shift16: 1'b0};
				end
				5'd1: begin
					mac_a   = MUL_A_W'(pitch_sens_q);
					mac_b   = MUL_B_W'(dp_q);
					mac_ctl = '{issue: 1'b1, clear: 1'b1, shift16: 1'b0};
				end
				5'd4: sin_phase = yaw_q;
				5'd5: sin_phase = yaw_q + QUARTER_TURN;
				5'd6: sin_phase = pitch_q;
				5'd7: sin_phase = pitch_q + QUARTER_TURN;
				5'd9: begin
					mac_a   = MUL_A_W'(cp_q);
					mac_b   = MUL_B_W'(sy_q);
					mac_ctl = '{issue: 1'b1, clear: 1'b1, shift16: 1'b0};
				end
				5'd10: begin
					mac_a   = MUL_A_W'(cp_q);
					mac_b   = MUL_B_W'(cy_q);
					mac_ctl = '{issue: 1'b1, clear: 1'b1, shift16: 1'b0};
				end
				5'd11: begin
					mac_a   = -MUL_A_W'(sy_q);
					mac_b   = MUL_B_W'(sp_q);
					mac_ctl = '{issue: 1'b1, clear: 1'b1, shift16: 1'b0};
				end
				5'd12: begin
					mac_a   = -MUL_A_W'(cy_q);
					mac_b   = MUL_B_W'(sp_q);
					mac_ctl = '{issue: 1'b1, clear: 1'b1, shift16: 1'b0};
				end
				5'd13: begin
					mac_a   = MUL_A_W'(dir_q[0]);
					mac_b   = MUL_B_W'(sy_q);
					mac_ctl = '{issue: 1'b1, clear: 1'b1, shift16: 1'b0};
				end
				5'd14: begin
					mac_a   = MUL_A_W'(dir_q[2]);
					mac_b   = MUL_B_W'(cy_q);
					mac_ctl = '{issue: 1'b1, clear: 1'b0, shift16: 1'b0};
				end
				default: ;
			endcase
		end else if (state_q == ST_TICK) begin
			unique case (step_q)
				5'd0: begin
					mac_a   = MUL_A_W'(elapsed_q);
					mac_b   = MUL_B_W'(move_speed_q);
					mac_ctl = '{issue: 1'b1, clear: 1'b1, shift16: 1'b0};
				end
				5'd3: begin
					mac_a   = MUL_A_W'(dir_sel);
					mac_b   = MUL_B_W'(fwd_q);
					mac_ctl = '{issue: 1'b1, clear: 1'b1, shift16: 1'b0};
				end
				5'd4: begin
					mac_a   = MUL_A_W'(rv_sel);
					mac_b   = MUL_B_W'(side_q);
					mac_ctl = '{issue: 1'b1, clear: 1'b0, shift16: 1'b0};
				end
				5'd6: begin
					mac_a   = MUL_A_W'(base_q[15:0]);
					mac_b   = MUL_B_W'(signed'(acc[19:0]));
					mac_ctl = '{issue: 1'b1, clear: 1'b1, shift16: 1'b0};
				end
				5'd7: begin
					mac_a   = MUL_A_W'(base_q[31:16]);
					mac_b   = MUL_B_W'(m_q);
					mac_ctl = '{issue: 1'b1, clear: 1'b0, shift16: 1'b1};
				end
				default: ;
			endcase
		end
	end

	// position step with rounding and saturation
	always_comb begin
		t_round = acc + ACC_W'(524288);
		pos_sum = 35'(pos_q[axis_q]) + 35'(signed'(t_round[53:20]));
		if (pos_sum > 35'sd2147483647) begin
			pos_new = 32'sh7FFFFFFF;
		end else if (pos_sum < -35'sd2147483648) begin
			pos_new = 32'sh80000000;
		end else begin
			pos_new = pos_sum[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			dy_q      <= s_tdata[11:0];
			dp_q      <= s_tdata[23:12];
			elapsed_q <= s_tdata[42:27];
		end
		if (state_q == ST_ROT) begin
			unique case (step_q)
				5'd5: sy_q <= sine;
				5'd6: cy_q <= sine;
				5'd7: sp_q <= sine;
				5'd8: cp_q <= sine;
				default: ;
			endcase
		end
		if (state_q == ST_TICK) begin
			if (step_q == 5'd2) begin
				base_q <= acc[31:0];
			end
			if (step_q == 5'd6) begin
				m_q <= acc[19:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_q       <= '0;
			axis_q       <= '0;
			move_speed_q <= 16'd384;
			yaw_sens_q   <= 16'd2670;
			pitch_sens_q <= 16'd2670;
			yaw_q        <= '0;
			pitch_q      <= '0;
			fwd_q        <= '0;
			side_q       <= '0;
			pos_q[0]     <= '0;
			pos_q[1]     <= '0;
			pos_q[2]     <= -32'sd327680;
			dir_q[0]     <= '0;
			dir_q[1]     <= '0;
			dir_q[2]     <= 16'sd20480;
			right_x_q    <= 16'sd4096;
			right_z_q    <= '0;
			up_q[0]      <= '0;
			up_q[1]      <= 16'sd4096;
			up_q[2]      <= '0;
			m_tvalid     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_MOVE_SPEED: move_speed_q <= cfg_data;
					CFG_YAW_SENS:   yaw_sens_q   <= cfg_data;
					CFG_PITCH_SENS: pitch_sens_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_DONE && (!m_tvalid || m_tready)) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						step_q <= '0;
						axis_q <= '0;
						unique case (s_tuser)
							OP_ROTATE: state_q <= ST_ROT;
							OP_TICK:   state_q <= ST_TICK;
							OP_KEY: begin
								unique case (s_tdata[25:24])
									KEY_FORWARD: fwd_q  <= step_count(fwd_q, s_tdata[26]);
									KEY_BACK:    fwd_q  <= step_count(fwd_q, !s_tdata[26]);
									KEY_LEFT:    side_q <= step_count(side_q, !s_tdata[26]);
									KEY_RIGHT:   side_q <= step_count(side_q, s_tdata[26]);
								endcase
								state_q <= ST_DONE;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_ROT: begin
					step_q <= step_q + 5'd1;
					unique case (step_q)
						5'd2: yaw_q   <= yaw_q + acc[PHASE_W-1:0];
						5'd3: pitch_q <= pitch_q + acc[PHASE_W-1:0];
						5'd9: begin
							dir_q[1]  <= 16'(sp_q);
							right_x_q <= -16'(cy_q);
							right_z_q <= 16'(sy_q);
						end
						5'd11: dir_q[0] <= q12(acc);
						5'd12: dir_q[2] <= q12(acc);
						5'd13: up_q[0]  <= q12(acc);
						5'd14: up_q[2]  <= q12(acc);
						5'd16: begin
							up_q[1] <= q12(acc);
							state_q <= ST_DONE;
						end
						default: ;
					endcase
				end
				ST_TICK: begin
					if (step_q == 5'd9) begin
						pos_q[axis_q] <= pos_new;
						if (axis_q == 2'd2) begin
							state_q <= ST_DONE;
						end else begin
							axis_q <= axis_q + 2'd1;
							step_q <= 5'd3;
						end
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				ST_DONE: begin
					// hold until the output slot is free
					if (!m_tvalid || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!m_tvalid || m_tready)) begin
			m_tdata <= {up_q[2], up_q[1], up_q[0], right_z_q, right_x_q,
				dir_q[2], dir_q[1], dir_q[0], pos_q[2], pos_q[1], pos_q[0]};
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_tready)
		else $error("input taken twice without finishing");

	a_rot_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROT) |-> (step_q <= 5'd16))
		else $error("rotate sequence overran");

	a_tick_axis_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TICK) |-> (axis_q <= 2'd2 && step_q <= 5'd9))
		else $error("tick sequence overran");

	a_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && m_tvalid && !m_tready) |=> (state_q == ST_DONE))
		else $error("result dropped while output stalled");

endmodule
`default_nettype wire
